// ===== rtl/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// Address pattern scorer package
// Shared constants, register indexes, link structs and the case fold helper.
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam int CHAR_W       = 8;
    localparam int WINDOW_DEPTH = 32;
    localparam int PATTERN_MAX  = 32;
    localparam int SCORE_LIMIT  = 32;
    localparam int PLEN_W       = 6;
    localparam int SCORE_W      = 6;
    localparam int MODE_W       = 2;
    localparam int CHAIN_W      = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;
    localparam int PAT_REGS     = 4;
    localparam int CHARS_PER_REG = CFG_DATA_W / CHAR_W;
    localparam int PAT_VEC_W    = WINDOW_DEPTH * CHAR_W;
    localparam int PLEN_CAP     = (PATTERN_MAX < WINDOW_DEPTH) ? PATTERN_MAX : WINDOW_DEPTH;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_T     = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

    localparam logic [MODE_W-1:0] MODE_PREFIX   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUFFIX   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ANYWHERE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BENCH    = 2'd3;

    localparam logic [CHAIN_W-1:0] CHAIN_HEX  = 2'd0;
    localparam logic [CHAIN_W-1:0] CHAIN_T    = 2'd1;
    localparam logic [CHAIN_W-1:0] CHAIN_NONE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_PAT0  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT1  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT2  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAT3  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PLEN  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CHAIN = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_CASE  = 3'd7;

    typedef struct packed {
        logic              feed;
        logic              fin;
        logic [CHAR_W-1:0] ch;
    } aps_op_t;

    typedef struct packed {
        logic              fill;
        logic              sa;
        logic [CHAR_W-1:0] ch;
    } aps_link_t;

    typedef struct packed {
        logic tok;
        logic hit;
        logic sa_new;
        logic ok;
    } aps_tap_t;

    typedef struct packed {
        logic                    lead_cond;
        logic                    lead_hit;
        logic                    found_hit;
        logic [WINDOW_DEPTH-1:0] sfx_ok;
    } aps_sum_t;

    function automatic logic [CHAR_W-1:0] fold_char(
        input logic [CHAR_W-1:0] c,
        input logic              exact
    );
        logic [CHAR_W-1:0] r;
        r = c;
        if (!exact && c >= CHAR_UP_A && c <= CHAR_UP_Z)
        begin
            r = c + CASE_DELTA;
        end
        return r;
    endfunction

endpackage

// ===== rtl/aps_feeder.sv =====
// ----------------------------------------------------------------------------
// Address pattern scorer input feeder
// Accepts address characters, holds the leading chain prefix characters
// until the strip decision is known, and replays them one per cycle unless stripped.
// ----------------------------------------------------------------------------
module aps_feeder
    import aps_pkg::*;
#(
    parameter int ADDRESS_MAX = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_ready,
    input  logic [CHAR_W-1:0]  addr_char,
    input  logic               last_char,
    input  logic [CHAIN_W-1:0] chain_kind,
    input  logic               exact_case,
    input  logic               room,
    output aps_op_t            op
);

    localparam int POS_W = $clog2(ADDRESS_MAX + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(ADDRESS_MAX);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CHAR_W-1:0] held_reg [2];
    logic [CHAR_W-1:0] held_next [2];
    logic [CHAR_W-1:0] pend0_reg, pend0_next;
    logic [CHAR_W-1:0] pend1_reg, pend1_next;
    logic [1:0]        pend_cnt_reg, pend_cnt_next;
    logic              pend_fin_reg, pend_fin_next;

    logic [1:0]        hold;
    logic [1:0]        n_extra;
    logic              in_range;
    logic              strip;
    logic              accept;
    logic              op_feed;
    logic              op_fin;
    logic [CHAR_W-1:0] op_raw;

    assign char_ready = (pend_cnt_reg == 2'd0) && room;
    assign accept     = char_valid && char_ready;

    always_comb
    begin
        unique case (chain_kind)
            CHAIN_HEX: hold = 2'd2;
            CHAIN_T:   hold = 2'd1;
            default:   hold = 2'd0;
        endcase
        in_range = pos_reg < POS_MAX;
        if (hold == 2'd2)
        begin
            strip = (held_reg[0] == CHAR_ZERO) && (held_reg[1] == CHAR_X);
        end
        else
        begin
            strip = held_reg[0] == CHAR_T;
        end

        op_feed       = 1'b0;
        op_fin        = 1'b0;
        op_raw        = addr_char;
        n_extra       = 2'd0;
        pos_next      = pos_reg;
        held_next[0]  = held_reg[0];
        held_next[1]  = held_reg[1];
        pend0_next    = pend0_reg;
        pend1_next    = pend1_reg;
        pend_cnt_next = pend_cnt_reg;
        pend_fin_next = pend_fin_reg;

        if (pend_cnt_reg != 2'd0)
        begin
            op_feed       = 1'b1;
            op_raw        = pend0_reg;
            op_fin        = pend_fin_reg && (pend_cnt_reg == 2'd1);
            pend0_next    = pend1_reg;
            pend_cnt_next = pend_cnt_reg - 2'd1;
        end
        else if (accept)
        begin
            if (!in_range)
            begin
                op_feed = 1'b0;
            end
            else if (pos_reg < POS_W'(hold))
            begin
                held_next[pos_reg[0]] = addr_char;
                if (last_char)
                begin
                    op_feed = 1'b1;
                    if (pos_reg != '0)
                    begin
                        op_raw     = held_reg[0];
                        pend0_next = addr_char;
                        n_extra    = 2'd1;
                    end
                end
            end
            else if ((pos_reg == POS_W'(hold)) && (hold != 2'd0) && !strip)
            begin
                op_feed = 1'b1;
                op_raw  = held_reg[0];
                if (hold == 2'd1)
                begin
                    pend0_next = addr_char;
                    n_extra    = 2'd1;
                end
                else
                begin
                    pend0_next = held_reg[1];
                    pend1_next = addr_char;
                    n_extra    = 2'd2;
                end
            end
            else
            begin
                op_feed = 1'b1;
            end

            op_fin        = last_char && (n_extra == 2'd0);
            pend_cnt_next = n_extra;
            pend_fin_next = last_char;
            if (last_char)
            begin
                pos_next = '0;
            end
            else if (in_range)
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    assign op.feed = op_feed;
    assign op.fin  = op_fin;
    assign op.ch   = fold_char(op_raw, exact_case);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            pend_cnt_reg <= 2'd0;
            pend_fin_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            pend_cnt_reg <= pend_cnt_next;
            pend_fin_reg <= pend_fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg[0] <= held_next[0];
        held_reg[1] <= held_next[1];
        pend0_reg   <= pend0_next;
        pend1_reg   <= pend1_next;
    end

endmodule

// ===== rtl/aps_cell.sv =====
// ----------------------------------------------------------------------------
// Address pattern scorer window cell
// Holds one body character of the recent window with fill, shift-and match
// and end-aligned compare bits; all but the compare bit go to the next cell.
// ----------------------------------------------------------------------------
module aps_cell
    import aps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  aps_op_t           op,
    input  logic              clr,
    input  aps_link_t         link_in,
    input  logic [CHAR_W-1:0] pat_char,
    input  logic [CHAR_W-1:0] apat_char,
    input  logic              active,
    output aps_link_t         link_out,
    output aps_tap_t          tap
);

    logic [CHAR_W-1:0] win_reg, win_next;
    logic              fill_reg, fill_next;
    logic              sa_reg, sa_next;
    logic              sfx_reg, sfx_next;
    logic              fill_eff;
    logic              sa_eff;
    logic              eq;
    logic              sa_new;

    assign fill_eff = fill_reg && !clr;
    assign sa_eff   = sa_reg && !clr;
    assign eq       = op.ch == pat_char;
    assign sa_new   = link_in.sa && eq;

    always_comb
    begin
        if (op.feed)
        begin
            win_next  = link_in.ch;
            fill_next = link_in.fill;
            sa_next   = sa_new;
            sfx_next  = link_in.ch == apat_char;
        end
        else
        begin
            win_next  = win_reg;
            fill_next = fill_eff;
            sa_next   = sa_eff;
            sfx_next  = sfx_reg;
        end
    end

    assign link_out.fill = fill_eff;
    assign link_out.sa   = sa_eff;
    assign link_out.ch   = win_reg;

    assign tap.tok    = active && link_in.fill && !fill_eff;
    assign tap.hit    = active && link_in.fill && !fill_eff && eq;
    assign tap.sa_new = sa_new;
    assign tap.ok     = active && fill_reg && sfx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 1'b0;
            sa_reg   <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            sa_reg   <= sa_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        sfx_reg <= sfx_next;
    end

endmodule

// ===== rtl/aps_tally.sv =====
// ----------------------------------------------------------------------------
// Address pattern scorer tally
// Keeps the leading match count and the found flag, forms the final score
// at the end of each address and queues scores for the output channel.
// ----------------------------------------------------------------------------
module aps_tally
    import aps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  aps_op_t            op,
    input  aps_sum_t           sum,
    input  logic [PLEN_W-1:0]  plen,
    input  logic [MODE_W-1:0]  match_mode,
    output logic               room,
    output logic               clr,
    output logic               score_valid,
    input  logic               score_ready,
    output logic [SCORE_W-1:0] score
);

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    logic [PLEN_W-1:0]  lead_reg, lead_next;
    logic               broken_reg, broken_next;
    logic               found_reg, found_next;
    logic               clr_reg;
    logic [SCORE_W-1:0] fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [WINDOW_DEPTH:0] ok_ext;
    logic [WINDOW_DEPTH:0] ok_inc;
    logic [WINDOW_DEPTH:0] first_zero;
    logic [SCORE_W-1:0]    suf;
    logic [SCORE_W-1:0]    raw;
    logic [SCORE_W-1:0]    final_score;
    logic                  push;
    logic                  pop;

    assign clr = clr_reg;

    always_comb
    begin
        lead_next   = clr_reg ? '0 : lead_reg;
        broken_next = broken_reg && !clr_reg;
        found_next  = found_reg && !clr_reg;
        if (op.feed)
        begin
            if (sum.lead_cond && !broken_next)
            begin
                if (sum.lead_hit)
                begin
                    lead_next = lead_next + PLEN_W'(1);
                end
                else
                begin
                    broken_next = 1'b1;
                end
            end
            if (sum.found_hit)
            begin
                found_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        ok_ext     = {1'b0, sum.sfx_ok};
        ok_inc     = ok_ext + (WINDOW_DEPTH + 1)'(1);
        first_zero = ~ok_ext & ok_inc;
        suf        = '0;
        for (int j = 0; j <= WINDOW_DEPTH; j++)
        begin
            if (first_zero[j])
            begin
                suf = suf | SCORE_W'(j);
            end
        end

        unique case (match_mode)
            MODE_PREFIX:   raw = (lead_reg > plen) ? plen : lead_reg;
            MODE_SUFFIX:   raw = suf;
            MODE_ANYWHERE: raw = found_reg ? plen : '0;
            MODE_BENCH:    raw = '0;
            default:       raw = '0;
        endcase
        if (plen == '0)
        begin
            raw = '0;
        end
        if ({1'b0, raw} > (SCORE_W + 1)'(SCORE_LIMIT))
        begin
            final_score = SCORE_W'(SCORE_LIMIT);
        end
        else
        begin
            final_score = raw;
        end
    end

    assign push        = clr_reg;
    assign pop         = score_valid && score_ready;
    assign score_valid = cnt_reg != '0;
    assign score       = fifo_mem[rd_ptr_reg];
    assign room        = ((CNT_W + 1)'(cnt_reg) + (CNT_W + 1)'(clr_reg))
                         < (CNT_W + 1)'(FIFO_DEPTH);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg   <= '0;
            broken_reg <= 1'b0;
            found_reg  <= 1'b0;
            clr_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            lead_reg   <= lead_next;
            broken_reg <= broken_next;
            found_reg  <= found_next;
            clr_reg    <= op.fin;
            cnt_reg    <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= final_score;
        end
    end

endmodule

// ===== rtl/address_pattern_scorer_top.sv =====
// ----------------------------------------------------------------------------
// Address pattern scorer
// Scores a character-serial address against a configured pattern in prefix,
// suffix or anywhere mode, using a row of window cells.
//
//   Channel   Handshake                   Word
//   --------  --------------------------  ------------------------------
//   char      char_valid / char_ready     addr_char, last_char
//   score     score_valid / score_ready   score
//   config    cfg_write                   cfg_index, cfg_data
//
// One character is taken per cycle, but not while held characters replay
// or the score queue lacks room. Unstripped held chain prefix characters,
// and those still held when an address ends, are replayed into the window
// one per cycle. A score is queued from the registered end-of-address flag.
// Reset clears all address state and sets the registers to their defaults.
// A four-word score queue absorbs output stalls; input waits when it fills.
// ----------------------------------------------------------------------------
module address_pattern_scorer_top
    import aps_pkg::*;
#(
    parameter int ADDRESS_MAX = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   char_valid,
    output logic                   char_ready,
    input  logic [CHAR_W-1:0]      addr_char,
    input  logic                   last_char,
    output logic                   score_valid,
    input  logic                   score_ready,
    output logic [SCORE_W-1:0]     score,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CFG_DATA_W-1:0] pat_reg [PAT_REGS];
    logic [PLEN_W-1:0]     plen_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic [CHAIN_W-1:0]    chain_reg;
    logic                  case_reg;

    logic [PLEN_W-1:0]     plen_eff;
    logic [PLEN_W-1:0]     shamt;
    logic [PAT_VEC_W-1:0]  pat_vec;
    logic [PAT_VEC_W-1:0]  rev_vec;
    logic [PAT_VEC_W-1:0]  apat_vec;

    aps_op_t   op;
    aps_sum_t  sum;
    aps_link_t link [WINDOW_DEPTH+1];
    aps_tap_t  taps [WINDOW_DEPTH];
    logic      room;
    logic      clr;
    logic [WINDOW_DEPTH-1:0] active;
    logic [WINDOW_DEPTH-1:0] tail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAT_REGS; i++)
            begin
                pat_reg[i] <= '0;
            end
            plen_reg  <= '0;
            mode_reg  <= MODE_PREFIX;
            chain_reg <= CHAIN_HEX;
            case_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PAT0:  pat_reg[0] <= cfg_data;
                REG_PAT1:  pat_reg[1] <= cfg_data;
                REG_PAT2:  pat_reg[2] <= cfg_data;
                REG_PAT3:  pat_reg[3] <= cfg_data;
                REG_PLEN:  plen_reg   <= cfg_data[PLEN_W-1:0];
                REG_MODE:  mode_reg   <= cfg_data[MODE_W-1:0];
                REG_CHAIN: chain_reg  <= cfg_data[CHAIN_W-1:0];
                REG_CASE:  case_reg   <= cfg_data[0];
                default:   plen_reg   <= plen_reg;
            endcase
        end
    end

    assign plen_eff = (plen_reg > PLEN_W'(PLEN_CAP)) ? PLEN_W'(PLEN_CAP) : plen_reg;
    assign shamt    = PLEN_W'(WINDOW_DEPTH) - plen_eff;
    assign apat_vec = rev_vec >> {shamt, 3'b000};

    assign link[0].fill = 1'b1;
    assign link[0].sa   = 1'b1;
    assign link[0].ch   = op.ch;

    aps_feeder #(
        .ADDRESS_MAX (ADDRESS_MAX)
    ) u_feeder (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .addr_char  (addr_char),
        .last_char  (last_char),
        .chain_kind (chain_reg),
        .exact_case (case_reg),
        .room       (room),
        .op         (op)
    );

    for (genvar k = 0; k < WINDOW_DEPTH; k++)
    begin : g_cell
        assign pat_vec[k*CHAR_W +: CHAR_W] =
            fold_char(pat_reg[k / CHARS_PER_REG][(k % CHARS_PER_REG)*CHAR_W +: CHAR_W],
                      case_reg);
        assign rev_vec[k*CHAR_W +: CHAR_W] =
            pat_vec[(WINDOW_DEPTH-1-k)*CHAR_W +: CHAR_W];
        assign active[k] = PLEN_W'(k) < plen_eff;
        assign tail[k]   = plen_eff == PLEN_W'(k + 1);

        aps_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .op        (op),
            .clr       (clr),
            .link_in   (link[k]),
            .pat_char  (pat_vec[k*CHAR_W +: CHAR_W]),
            .apat_char (apat_vec[k*CHAR_W +: CHAR_W]),
            .active    (active[k]),
            .link_out  (link[k+1]),
            .tap       (taps[k])
        );
    end

    always_comb
    begin
        sum.lead_cond = 1'b0;
        sum.lead_hit  = 1'b0;
        sum.found_hit = 1'b0;
        for (int k = 0; k < WINDOW_DEPTH; k++)
        begin
            sum.lead_cond = sum.lead_cond | taps[k].tok;
            sum.lead_hit  = sum.lead_hit | taps[k].hit;
            sum.found_hit = sum.found_hit | (taps[k].sa_new & tail[k]);
            sum.sfx_ok[k] = taps[k].ok;
        end
    end

    aps_tally u_tally (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .sum         (sum),
        .plen        (plen_eff),
        .match_mode  (mode_reg),
        .room        (room),
        .clr         (clr),
        .score_valid (score_valid),
        .score_ready (score_ready),
        .score       (score)
    );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Address pattern scorer testbench
// Streams address characters through the scorer under random valid and ready
// gaps, predicts every score with a behavioral model kept in step with the
// configuration writes, and compares each score word as it leaves the block.
// Directed addresses cover the chain prefixes, every match mode, case folding
// and the corner cases; long addresses and random traffic follow.
// ----------------------------------------------------------------------------
module testbench;
    import aps_pkg::*;

    localparam int ADDR_LIMIT    = 64;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TEXT_W        = PAT_REGS * CFG_DATA_W;
    localparam logic [CHAIN_W-1:0] CHAIN_SPARE = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   char_valid = 1'b0;
    logic                   char_ready;
    logic [CHAR_W-1:0]      addr_char = '0;
    logic                   last_char = 1'b0;
    logic                   score_valid;
    logic                   score_ready = 1'b0;
    logic [SCORE_W-1:0]     score;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic [CFG_DATA_W-1:0] pat_word [PAT_REGS];
    int                    pat_len;
    logic [MODE_W-1:0]     mode_sel;
    logic [CHAIN_W-1:0]    chain_sel;
    logic                  exact_cmp;

    logic [CHAR_W-1:0] body_win [WINDOW_DEPTH];
    logic [CHAR_W-1:0] held_chars [2];
    int                char_pos;
    int                body_len;
    int                lead_count;
    bit                lead_broken;
    bit                pattern_seen;

    logic [SCORE_W-1:0] pending_scores [$];
    logic [CHAR_W-1:0]  addr_text [$];
    logic [SCORE_W-1:0] want_score;
    int                 mismatches = 0;
    int                 idle_pct = 0;
    int                 sent_items = 0;
    int                 quiet_cycles = 0;
    int                 ready_hold = 0;

    address_pattern_scorer_top #(
        .ADDRESS_MAX(ADDR_LIMIT)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .char_valid(char_valid),
        .char_ready(char_ready),
        .addr_char(addr_char),
        .last_char(last_char),
        .score_valid(score_valid),
        .score_ready(score_ready),
        .score(score),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [CHAR_W-1:0] fold_to_lower(input logic [CHAR_W-1:0] c);
        if (!exact_cmp && c >= CHAR_UP_A && c <= CHAR_UP_Z)
        begin
            return c + CASE_DELTA;
        end
        return c;
    endfunction

    function automatic int live_length();
        return (pat_len > PLEN_CAP) ? PLEN_CAP : pat_len;
    endfunction

    function automatic logic [CHAR_W-1:0] raw_pattern_char(input int k);
        return pat_word[k / CHARS_PER_REG][(k % CHARS_PER_REG) * CHAR_W +: CHAR_W];
    endfunction

    function automatic logic [CHAR_W-1:0] pattern_char(input int k);
        return fold_to_lower(raw_pattern_char(k));
    endfunction

    function automatic void clear_scan();
        int i;
        for (i = 0; i < WINDOW_DEPTH; i++)
        begin
            body_win[i] = '0;
        end
        held_chars[0] = '0;
        held_chars[1] = '0;
        char_pos = 0;
        body_len = 0;
        lead_count = 0;
        lead_broken = 1'b0;
        pattern_seen = 1'b0;
    endfunction

    function automatic void shift_in_body(input logic [CHAR_W-1:0] raw);
        int                plen;
        int                i;
        bit                whole;
        logic [CHAR_W-1:0] c;
        plen = live_length();
        c = fold_to_lower(raw);
        if (body_len < plen && !lead_broken)
        begin
            if (c == pattern_char(body_len))
            begin
                lead_count++;
            end
            else
            begin
                lead_broken = 1'b1;
            end
        end
        for (i = WINDOW_DEPTH - 1; i > 0; i--)
        begin
            body_win[i] = body_win[i - 1];
        end
        body_win[0] = c;
        if (body_len < 127)
        begin
            body_len++;
        end
        if (plen > 0 && body_len >= plen)
        begin
            whole = 1'b1;
            for (i = 0; i < plen; i++)
            begin
                if (body_win[plen - 1 - i] != pattern_char(i))
                begin
                    whole = 1'b0;
                end
            end
            if (whole)
            begin
                pattern_seen = 1'b1;
            end
        end
    endfunction

    function automatic logic [SCORE_W-1:0] closing_score();
        int plen;
        int n;
        int s;
        int i;
        plen = live_length();
        s = 0;
        if (mode_sel == MODE_BENCH || plen == 0)
        begin
            return '0;
        end
        if (mode_sel == MODE_PREFIX)
        begin
            s = (lead_count < plen) ? lead_count : plen;
        end
        else if (mode_sel == MODE_SUFFIX)
        begin
            n = (body_len < plen) ? body_len : plen;
            for (i = 0; i < n && body_win[i] == pattern_char(plen - 1 - i); i++)
            begin
                s++;
            end
        end
        else
        begin
            s = pattern_seen ? plen : 0;
        end
        if (s > SCORE_LIMIT)
        begin
            s = SCORE_LIMIT;
        end
        return s[SCORE_W-1:0];
    endfunction

    function automatic void predict_char(input logic [CHAR_W-1:0] c, input logic last);
        int hold;
        int p;
        int i;
        bit strip;
        hold = (chain_sel == CHAIN_HEX) ? 2 : ((chain_sel == CHAIN_T) ? 1 : 0);
        p = char_pos;
        if (p < ADDR_LIMIT)
        begin
            if (p < hold)
            begin
                held_chars[p % 2] = c;
                if (last)
                begin
                    for (i = 0; i <= p; i++)
                    begin
                        shift_in_body(held_chars[i % 2]);
                    end
                end
            end
            else
            begin
                if (p == hold && hold > 0)
                begin
                    if (hold == 2)
                    begin
                        strip = held_chars[0] == CHAR_ZERO && held_chars[1] == CHAR_X;
                    end
                    else
                    begin
                        strip = held_chars[0] == CHAR_T;
                    end
                    if (!strip)
                    begin
                        for (i = 0; i < hold; i++)
                        begin
                            shift_in_body(held_chars[i % 2]);
                        end
                    end
                end
                shift_in_body(c);
            end
            char_pos = p + 1;
        end
        if (last)
        begin
            pending_scores.push_back(closing_score());
            clear_scan();
        end
    endfunction

    function automatic logic [TEXT_W-1:0] pack_text(input string s);
        logic [TEXT_W-1:0] v;
        int                k;
        v = '0;
        for (k = 0; k < s.len(); k++)
        begin
            v[k * CHAR_W +: CHAR_W] = s[k];
        end
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] random_symbol();
        case ($urandom_range(0, 9))
            0, 1: return CHAR_W'("a" + $urandom_range(0, 5));
            2, 3: return CHAR_W'("A" + $urandom_range(0, 5));
            4, 5: return CHAR_W'("0" + $urandom_range(0, 9));
            6: return CHAR_X;
            7: return CHAR_T;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] swap_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] low;
        low = c | CASE_DELTA;
        if (low >= "a" && low <= "z")
        begin
            return c ^ CASE_DELTA;
        end
        return c;
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s: expected %0d, actual %0d", $realtime, what, want, got);
        end
    endtask

    task automatic reset_model();
        int i;
        for (i = 0; i < PAT_REGS; i++)
        begin
            pat_word[i] = '0;
        end
        pat_len = 0;
        mode_sel = MODE_PREFIX;
        chain_sel = CHAIN_HEX;
        exact_cmp = 1'b1;
        clear_scan();
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        char_valid <= 1'b1;
        addr_char <= c;
        last_char <= last;
        @(posedge clk);
        while (!char_ready)
        begin
            @(posedge clk);
        end
        predict_char(c, last);
        sent_items++;
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < addr_text.size(); i++)
        begin
            send_char(addr_text[i], i == addr_text.size() - 1);
        end
    endtask

    task automatic put_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
        begin
            addr_text.push_back(s[k]);
        end
    endtask

    task automatic settle();
        char_valid <= 1'b0;
        while (pending_scores.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        case (idx)
            REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: pat_word[idx[1:0]] = d;
            REG_PLEN: pat_len = int'(d[PLEN_W-1:0]);
            REG_MODE: mode_sel = d[MODE_W-1:0];
            REG_CHAIN: chain_sel = d[CHAIN_W-1:0];
            REG_CASE: exact_cmp = d[0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [TEXT_W-1:0] text, input int plen,
                               input int mode, input int chain, input bit exact);
        settle();
        write_reg(REG_PAT0, text[0 * CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PAT1, text[1 * CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PAT2, text[2 * CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PAT3, text[3 * CFG_DATA_W +: CFG_DATA_W]);
        write_reg(REG_PLEN, CFG_DATA_W'(plen));
        write_reg(REG_MODE, CFG_DATA_W'(mode));
        write_reg(REG_CHAIN, CFG_DATA_W'(chain));
        write_reg(REG_CASE, CFG_DATA_W'(exact));
        cfg_write <= 1'b0;
    endtask

    task automatic random_config();
        logic [TEXT_W-1:0] text;
        int                k;
        int                plen;
        for (k = 0; k < WINDOW_DEPTH; k++)
        begin
            text[k * CHAR_W +: CHAR_W] = random_symbol();
        end
        case ($urandom_range(0, 9))
            0: text = '1;
            1: text = '0;
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0: plen = 0;
            1: plen = PLEN_CAP;
            2: plen = $urandom_range(PLEN_CAP + 1, (1 << PLEN_W) - 1);
            3: plen = $urandom_range(7, PLEN_CAP - 1);
            default: plen = $urandom_range(1, 6);
        endcase
        load_config(text, plen, $urandom_range(MODE_PREFIX, MODE_BENCH),
                    $urandom_range(CHAIN_HEX, CHAIN_SPARE), $urandom_range(0, 1));
    endtask

    task automatic build_random_address();
        int                plen;
        int                shape;
        int                r;
        int                i;
        int                start;
        int                stop;
        logic [CHAR_W-1:0] c;
        addr_text.delete();
        plen = live_length();
        r = $urandom_range(0, 7);
        if (r < 5)
        begin
            if (chain_sel == CHAIN_T || (chain_sel != CHAIN_HEX && $urandom_range(0, 1)))
            begin
                addr_text.push_back(CHAR_T);
            end
            else
            begin
                addr_text.push_back(CHAR_ZERO);
                addr_text.push_back(CHAR_X);
            end
        end
        else if (r == 5)
        begin
            addr_text.push_back(CHAR_ZERO);
            addr_text.push_back(random_symbol());
        end
        else if (r == 6)
        begin
            addr_text.push_back(random_symbol());
        end
        shape = $urandom_range(0, 4);
        start = 0;
        stop = plen;
        if (shape == 0)
        begin
            stop = $urandom_range(0, plen);
        end
        if (shape == 1)
        begin
            start = $urandom_range(0, plen);
        end
        if (shape == 1 || shape == 2)
        begin
            repeat ($urandom_range(0, 4)) addr_text.push_back(random_symbol());
        end
        if (shape < 3)
        begin
            for (i = start; i < stop; i++)
            begin
                c = raw_pattern_char(i);
                if ($urandom_range(0, 3) == 0)
                begin
                    c = swap_case(c);
                end
                addr_text.push_back(c);
            end
        end
        if (shape == 0 || shape == 2)
        begin
            repeat ($urandom_range(0, 3)) addr_text.push_back(random_symbol());
        end
        else if (shape == 3)
        begin
            repeat ($urandom_range(0, 8)) addr_text.push_back(random_symbol());
        end
        else if (shape == 4)
        begin
            repeat ($urandom_range(0, 1)) addr_text.push_back(random_symbol());
        end
        if (addr_text.size() > 0 && $urandom_range(0, 3) == 0)
        begin
            addr_text[$urandom_range(0, addr_text.size() - 1)] = random_symbol();
        end
        if (addr_text.size() == 0)
        begin
            addr_text.push_back(random_symbol());
        end
    endtask

    task automatic test_reset_defaults();
        idle_pct = 20;
        addr_text.delete();
        put_text("0x");
        send_text();
    endtask

    task automatic test_prefix_folding();
        load_config(pack_text("aB"), 2, MODE_PREFIX, CHAIN_HEX, 1'b0);
        addr_text.delete();
        put_text("0xAb");
        send_text();
        addr_text.delete();
        put_text("a");
        send_text();
        addr_text.delete();
        put_text("0ya");
        send_text();
    endtask

    task automatic test_suffix_long_length();
        load_config('1, (1 << PLEN_W) - 1, MODE_SUFFIX, CHAIN_T, 1'b1);
        addr_text.delete();
        addr_text.push_back(CHAR_T);
        addr_text.push_back(8'hFF);
        addr_text.push_back(8'hFF);
        send_text();
        addr_text.delete();
        addr_text.push_back(CHAR_T);
        send_text();
    endtask

    task automatic test_anywhere_spare_chain();
        load_config('0, 1, MODE_ANYWHERE, CHAIN_SPARE, 1'b1);
        addr_text.delete();
        addr_text.push_back(8'hFF);
        addr_text.push_back(8'h00);
        addr_text.push_back(8'hFF);
        send_text();
        addr_text.delete();
        put_text("Tx");
        send_text();
    endtask

    task automatic test_benchmark_mode();
        load_config(pack_text("ab"), 2, MODE_BENCH, CHAIN_NONE, 1'b0);
        addr_text.delete();
        put_text("ab");
        send_text();
    endtask

    task automatic test_long_address();
        int lens [4] = '{63, 64, 65, 80};
        int spots [2] = '{60, 62};
        int i;
        load_config(pack_text("abab"), 4, MODE_SUFFIX, CHAIN_HEX, 1'b1);
        idle_pct = 15;
        for (i = 0; i < 4; i++)
        begin
            addr_text.delete();
            put_text("0x");
            repeat (lens[i] - 2) addr_text.push_back(CHAR_W'("a" + $urandom_range(0, 1)));
            send_text();
        end
        // The match that straddles the length cap must not count.
        load_config(pack_text("abba"), 4, MODE_ANYWHERE, CHAIN_NONE, 1'b1);
        for (i = 0; i < 2; i++)
        begin
            addr_text.delete();
            repeat (spots[i]) addr_text.push_back("a");
            put_text("abbaaa");
            send_text();
        end
    endtask

    task automatic test_random_traffic(input int quota, input bit quiet);
        int goal;
        int phase_end;
        goal = sent_items + quota;
        while (sent_items < goal)
        begin
            random_config();
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 30;
            endcase
            if (quiet)
            begin
                idle_pct = 0;
            end
            phase_end = sent_items + $urandom_range(12, 30);
            while (sent_items < phase_end && sent_items < goal)
            begin
                build_random_address();
                send_text();
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            score_ready <= 1'b0;
        end
        else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            ready_hold = $urandom_range(1, 6) - 1;
            score_ready <= 1'b0;
        end
        else
        begin
            score_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && score_valid && score_ready)
        begin
            if (pending_scores.size() == 0)
            begin
                note_mismatch("score word with none pending", -1, score);
            end
            else
            begin
                want_score = pending_scores.pop_front();
                if (score !== want_score)
                begin
                    note_mismatch("score", want_score, score);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (char_valid && char_ready) || (score_valid && score_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        reset_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_prefix_folding();
        test_suffix_long_length();
        test_anywhere_spare_chain();
        test_benchmark_mode();
        test_long_address();
        test_random_traffic(140, 1'b0);
        test_random_traffic(35, 1'b1);
        settle();
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
